[rtl/next_fit_slot_allocator_unit_assert.svh]
// Assertion macros for the next-fit slot allocator.
// Depends on nothing; included by the modules that carry checks.
`ifndef NEXT_FIT_SLOT_ALLOCATOR_UNIT_ASSERT_SVH
`define NEXT_FIT_SLOT_ALLOCATOR_UNIT_ASSERT_SVH

// expression holds at every edge out of reset
`define NFSA_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("nfsa: invariant violated");

// consequent holds in the same cycle as the antecedent
`define NFSA_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("nfsa: implication violated");

// consequent holds in the cycle after the antecedent
`define NFSA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("nfsa: next-cycle implication violated");

`endif

[rtl/nfsa_pkg.sv]
// Shared constants, codes, control word type and microprogram of the slot allocator.
// Depends on nothing.
package nfsa_pkg;

   localparam int TABLE_SLOTS_DEFAULT = 64;
   localparam int HANDLE_BITS_DEFAULT = 32;
   localparam int FIRST_SLOT          = 2;

   localparam int MODE_W     = 2;
   localparam int INDEX_W    = 8;
   localparam int STATUS_W   = 2;
   localparam int SLOT_OUT_W = 6;

   localparam logic [MODE_W-1:0] MODE_ALLOC  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd1;
   localparam logic [MODE_W-1:0] MODE_FREE   = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_NULL    = 2'd3;

   typedef logic [3:0] step_type;

   localparam step_type STEP_WAIT    = 4'd0;
   localparam step_type STEP_SORT    = 4'd1;
   localparam step_type STEP_NULLCHK = 4'd2;
   localparam step_type STEP_SCAN    = 4'd3;
   localparam step_type STEP_PICK    = 4'd4;
   localparam step_type STEP_FULL    = 4'd5;
   localparam step_type STEP_STORE   = 4'd6;
   localparam step_type STEP_INDEX   = 4'd7;
   localparam step_type STEP_FETCH   = 4'd8;
   localparam step_type STEP_INVALID = 4'd9;
   localparam step_type STEP_NULLRES = 4'd10;
   localparam step_type STEP_EMIT    = 4'd11;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LATCH,
      OP_SCAN_INIT,
      OP_SCAN,
      OP_FULL,
      OP_STORE,
      OP_READ,
      OP_HELD,
      OP_INVALID,
      OP_NULL,
      OP_EMIT
   } op_type;

   typedef enum logic [2:0] {
      COND_ALWAYS,
      COND_NO_REQ,
      COND_NOT_ALLOC,
      COND_NULL,
      COND_SCAN_BUSY,
      COND_SLOT_FREE,
      COND_BAD_REQ,
      COND_OUT_BUSY
   } cond_type;

   // jump taken when the condition holds, else go to next
   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type jump;
      step_type next;
   } ctrl_word_type;

   function automatic ctrl_word_type ucode_word(input step_type step);
      ctrl_word_type w;
      unique case (step)
         STEP_WAIT:    w = '{OP_LATCH,     COND_NO_REQ,    STEP_WAIT,    STEP_SORT};
         STEP_SORT:    w = '{OP_NONE,      COND_NOT_ALLOC, STEP_INDEX,   STEP_NULLCHK};
         STEP_NULLCHK: w = '{OP_SCAN_INIT, COND_NULL,      STEP_NULLRES, STEP_SCAN};
         STEP_SCAN:    w = '{OP_SCAN,      COND_SCAN_BUSY, STEP_SCAN,    STEP_PICK};
         STEP_PICK:    w = '{OP_NONE,      COND_SLOT_FREE, STEP_STORE,   STEP_FULL};
         STEP_FULL:    w = '{OP_FULL,      COND_ALWAYS,    STEP_EMIT,    STEP_EMIT};
         STEP_STORE:   w = '{OP_STORE,     COND_ALWAYS,    STEP_EMIT,    STEP_EMIT};
         STEP_INDEX:   w = '{OP_READ,      COND_BAD_REQ,   STEP_INVALID, STEP_FETCH};
         STEP_FETCH:   w = '{OP_HELD,      COND_ALWAYS,    STEP_EMIT,    STEP_EMIT};
         STEP_INVALID: w = '{OP_INVALID,   COND_ALWAYS,    STEP_EMIT,    STEP_EMIT};
         STEP_NULLRES: w = '{OP_NULL,      COND_ALWAYS,    STEP_EMIT,    STEP_EMIT};
         STEP_EMIT:    w = '{OP_EMIT,      COND_OUT_BUSY,  STEP_EMIT,    STEP_WAIT};
         default:      w = '{OP_NONE,      COND_ALWAYS,    STEP_WAIT,    STEP_WAIT};
      endcase
      return w;
   endfunction

endpackage

[rtl/nfsa_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Depends on nfsa_pkg for default sizes.
module nfsa_ram #(
   parameter int WIDTH = nfsa_pkg::HANDLE_BITS_DEFAULT,
   parameter int DEPTH = nfsa_pkg::TABLE_SLOTS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/next_fit_slot_allocator_unit.sv]
// Top level of the next-fit slot allocator: microcoded sequencer, occupancy bits,
// handle RAM and result register. Depends on nfsa_pkg, nfsa_ram and the assert header.
//
//  channel | dir | tdata (low bit up)                          | handshake
//  --------+-----+---------------------------------------------+----------------
//  req_    | in  | mode[2], handle[HANDLE_BITS], slot_index[8] | req_tvalid/tready
//  rsp_    | out | status[2], slot_out[6], handle_out[HANDLE_BITS] | rsp_tvalid/tready
//
//  Steps: an allocate probes k slots (1 .. TABLE_SLOTS-2), one occupancy bit per
//  cycle in the scan step; a null handle skips the scan; look up and free read the
//  handle RAM, whose read data is registered, before the result is formed.
//  Reset: synchronous, active high; clears all occupancy bits at once and sets the
//  hint to slot 2. No clearing pass, so requests are taken straight out of reset.
//  Stalls: a finished result waits in the output register; the next request is
//  taken meanwhile and only its own emit step waits for that register to drain.
`include "next_fit_slot_allocator_unit_assert.svh"

module next_fit_slot_allocator_unit #(
   parameter int TABLE_SLOTS = nfsa_pkg::TABLE_SLOTS_DEFAULT,
   parameter int HANDLE_BITS = nfsa_pkg::HANDLE_BITS_DEFAULT,
   localparam int REQ_TDATA_W =
      ((nfsa_pkg::MODE_W + HANDLE_BITS + nfsa_pkg::INDEX_W + 7) / 8) * 8,
   localparam int RSP_TDATA_W =
      ((nfsa_pkg::STATUS_W + nfsa_pkg::SLOT_OUT_W + HANDLE_BITS + 7) / 8) * 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // mode, handle, slot_index, zero pad
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata   // status, slot_out, handle_out, zero pad
);

   localparam int AW = $clog2(TABLE_SLOTS);
   localparam int HW = $clog2(TABLE_SLOTS + 1);
   localparam int MW = nfsa_pkg::MODE_W;
   localparam int IW = nfsa_pkg::INDEX_W;
   localparam int SW = nfsa_pkg::STATUS_W;
   localparam int OW = nfsa_pkg::SLOT_OUT_W;

   // unpack the request transfer
   logic [MW-1:0]          req_mode;
   logic [HANDLE_BITS-1:0] req_handle;
   logic [IW-1:0]          req_index;
   logic [IW-2:0]          index_mag;
   logic                   index_bad;

   assign req_mode   = req_tdata[MW-1:0];
   assign req_handle = req_tdata[MW +: HANDLE_BITS];
   assign req_index  = req_tdata[MW + HANDLE_BITS +: IW];
   assign index_mag  = req_index[IW-2:0];

   // negative, reserved or past the table end
   assign index_bad = req_index[IW-1]
                   || (index_mag < (IW-1)'(nfsa_pkg::FIRST_SLOT))
                   || (32'(index_mag) >= 32'(TABLE_SLOTS));

   // sequencer
   nfsa_pkg::step_type      step_ff, step_in;
   nfsa_pkg::ctrl_word_type ctrl;
   logic                    cond_true;

   // request registers
   logic [MW-1:0]          mode_ff, mode_in;
   logic [HANDLE_BITS-1:0] handle_ff, handle_in;
   logic [AW-1:0]          slot_ff, slot_in;
   logic                   bad_ff, bad_in;

   // scan datapath and table state
   logic [AW-1:0]          scan_idx_ff, scan_idx_in;
   logic [AW-1:0]          scan_cnt_ff, scan_cnt_in;
   logic [HW-1:0]          hint_ff, hint_in;
   logic [TABLE_SLOTS-1:0] occ_ff, occ_in;
   logic                   scan_busy;

   // result and output registers
   logic [SW-1:0]          res_status_ff, res_status_in;
   logic [OW-1:0]          res_slot_ff, res_slot_in;
   logic [HANDLE_BITS-1:0] res_handle_ff, res_handle_in;
   logic [SW-1:0]          out_status_ff, out_status_in;
   logic [OW-1:0]          out_slot_ff, out_slot_in;
   logic [HANDLE_BITS-1:0] out_handle_ff, out_handle_in;
   logic                   out_valid_ff, out_valid_in;
   logic                   out_busy;
   logic                   out_load;

   // RAM port
   logic                   ram_wr_en;
   logic                   ram_rd_en;
   logic [HANDLE_BITS-1:0] ram_rd_data;

   assign ctrl      = nfsa_pkg::ucode_word(step_ff);
   assign scan_busy = occ_ff[scan_idx_ff] && (scan_cnt_ff != AW'(1));
   assign out_busy  = out_valid_ff && !rsp_tready;
   assign out_load  = (ctrl.op == nfsa_pkg::OP_EMIT) && !out_busy;

   // hold ready low while in reset so no transfer is dropped
   assign req_tready = (ctrl.op == nfsa_pkg::OP_LATCH) && !reset;
   assign ram_wr_en  = (ctrl.op == nfsa_pkg::OP_STORE);
   assign ram_rd_en  = (ctrl.op == nfsa_pkg::OP_READ);

   // branch condition
   always_comb begin
      unique case (ctrl.cond)
         nfsa_pkg::COND_ALWAYS:    cond_true = 1'b1;
         nfsa_pkg::COND_NO_REQ:    cond_true = !req_tvalid;
         nfsa_pkg::COND_NOT_ALLOC: cond_true = (mode_ff != nfsa_pkg::MODE_ALLOC);
         nfsa_pkg::COND_NULL:      cond_true = (handle_ff == '0);
         nfsa_pkg::COND_SCAN_BUSY: cond_true = scan_busy;
         nfsa_pkg::COND_SLOT_FREE: cond_true = !occ_ff[scan_idx_ff];
         nfsa_pkg::COND_BAD_REQ:   cond_true = ((mode_ff != nfsa_pkg::MODE_LOOKUP)
                                                && (mode_ff != nfsa_pkg::MODE_FREE))
                                               || bad_ff || !occ_ff[slot_ff];
         nfsa_pkg::COND_OUT_BUSY:  cond_true = out_busy;
         default:                  cond_true = 1'b0;
      endcase
   end

   // step counter
   always_comb begin
      step_in = cond_true ? ctrl.jump : ctrl.next;
   end

   // datapath actions selected by the control word
   always_comb begin
      mode_in       = mode_ff;
      handle_in     = handle_ff;
      slot_in       = slot_ff;
      bad_in        = bad_ff;
      scan_idx_in   = scan_idx_ff;
      scan_cnt_in   = scan_cnt_ff;
      hint_in       = hint_ff;
      occ_in        = occ_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      res_handle_in = res_handle_ff;

      case (ctrl.op)
         nfsa_pkg::OP_LATCH: begin
            if (req_tvalid) begin
               mode_in   = req_mode;
               handle_in = req_handle;
               slot_in   = AW'(index_mag);
               bad_in    = index_bad;
            end
         end
         nfsa_pkg::OP_SCAN_INIT: begin
            // a hint at the table end starts straight from the first usable slot
            scan_idx_in = (hint_ff == HW'(TABLE_SLOTS)) ? AW'(nfsa_pkg::FIRST_SLOT)
                                                        : AW'(hint_ff);
            scan_cnt_in = AW'(TABLE_SLOTS - nfsa_pkg::FIRST_SLOT);
         end
         nfsa_pkg::OP_SCAN: begin
            // advance past an occupied slot; hold on a free one or the last probe
            if (scan_busy) begin
               scan_idx_in = (scan_idx_ff == AW'(TABLE_SLOTS - 1))
                           ? AW'(nfsa_pkg::FIRST_SLOT) : scan_idx_ff + AW'(1);
               scan_cnt_in = scan_cnt_ff - AW'(1);
            end
         end
         nfsa_pkg::OP_FULL: begin
            res_status_in = nfsa_pkg::STATUS_FULL;
            res_slot_in   = '0;
            res_handle_in = handle_ff;
         end
         nfsa_pkg::OP_STORE: begin
            occ_in[scan_idx_ff] = 1'b1;
            hint_in             = HW'(scan_idx_ff) + HW'(1);
            res_status_in       = nfsa_pkg::STATUS_OK;
            res_slot_in         = OW'(scan_idx_ff);
            res_handle_in       = '0;
         end
         nfsa_pkg::OP_HELD: begin
            if (mode_ff == nfsa_pkg::MODE_FREE) begin
               occ_in[slot_ff] = 1'b0;
            end
            res_status_in = nfsa_pkg::STATUS_OK;
            res_slot_in   = '0;
            res_handle_in = ram_rd_data;
         end
         nfsa_pkg::OP_INVALID: begin
            res_status_in = nfsa_pkg::STATUS_INVALID;
            res_slot_in   = '0;
            res_handle_in = '0;
         end
         nfsa_pkg::OP_NULL: begin
            res_status_in = nfsa_pkg::STATUS_NULL;
            res_slot_in   = '0;
            res_handle_in = '0;
         end
         default: begin
         end
      endcase
   end

   // output register: load from the result register, drop valid on a transfer
   always_comb begin
      out_status_in = out_status_ff;
      out_slot_in   = out_slot_ff;
      out_handle_in = out_handle_ff;
      out_valid_in  = out_valid_ff && !rsp_tready;
      if (out_load) begin
         out_status_in = res_status_ff;
         out_slot_in   = res_slot_ff;
         out_handle_in = res_handle_ff;
         out_valid_in  = 1'b1;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= nfsa_pkg::STEP_WAIT;
         hint_ff      <= HW'(nfsa_pkg::FIRST_SLOT);
         occ_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         hint_ff      <= hint_in;
         occ_ff       <= occ_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      handle_ff     <= handle_in;
      slot_ff       <= slot_in;
      bad_ff        <= bad_in;
      scan_idx_ff   <= scan_idx_in;
      scan_cnt_ff   <= scan_cnt_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      res_handle_ff <= res_handle_in;
      out_status_ff <= out_status_in;
      out_slot_ff   <= out_slot_in;
      out_handle_ff <= out_handle_in;
   end

   // handle store; occupancy lives in occ_ff, so free needs no RAM write
   nfsa_ram #(
      .WIDTH(HANDLE_BITS),
      .DEPTH(TABLE_SLOTS)
   ) u_handles (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(scan_idx_ff),
      .wr_data(handle_ff),
      .rd_en  (ram_rd_en),
      .rd_addr(slot_ff),
      .rd_data(ram_rd_data)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'({out_handle_ff, out_slot_ff, out_status_ff});

   `NFSA_ASSERT_ALWAYS(a_hint_range, clock, reset, (hint_ff >= HW'(nfsa_pkg::FIRST_SLOT)) && (hint_ff <= HW'(TABLE_SLOTS)))
   `NFSA_ASSERT_IMPLY(a_scan_no_reserved, clock, reset, ctrl.op == nfsa_pkg::OP_SCAN, scan_idx_ff >= AW'(nfsa_pkg::FIRST_SLOT))
   `NFSA_ASSERT_NEXT(a_store_marks, clock, reset, ctrl.op == nfsa_pkg::OP_STORE, occ_ff[$past(scan_idx_ff)] && (hint_ff == HW'($past(scan_idx_ff)) + HW'(1)))
   `NFSA_ASSERT_NEXT(a_transfer_dispatch, clock, reset, req_tvalid && req_tready, step_ff == nfsa_pkg::STEP_SORT)

endmodule

[test/next_fit_slot_allocator_unit_test.sv]
// Self-checking testbench for the next-fit slot allocator: directed table, then random
// fill/drain traffic with random idling, results checked against typed or shadow outcomes.
// Depends on nfsa_pkg and next_fit_slot_allocator_unit.
`timescale 1ns / 1ps

module next_fit_slot_allocator_unit_test;

   localparam int SLOTS      = 64;
   localparam int REQ_W      = 48;   // mode 2 + handle 32 + slot_index 8, padded to bytes
   localparam int RSP_W      = 40;   // status 2 + slot_out 6 + handle_out 32
   localparam int RUN_LIMIT  = 400000;
   localparam int TAIL_WAIT  = 80;   // longest allocate probes 62 slots
   localparam int RAND_ITEMS = 300;  // per idling phase, three phases

   // mode 3 has no meaning in the package; the block must reject it
   localparam logic [nfsa_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

   typedef struct packed {
      logic [nfsa_pkg::STATUS_W-1:0]   status;
      logic [nfsa_pkg::SLOT_OUT_W-1:0] slot;
      logic [31:0]                     handle;
   } outcome_type;

   typedef struct packed {
      logic [nfsa_pkg::MODE_W-1:0]  mode;
      logic [31:0]                  handle;
      logic [nfsa_pkg::INDEX_W-1:0] index;
      logic                         known;   // outcome typed in below, else from the shadow
      outcome_type                  want;
   } dir_row_type;

   // Directed rows: null handle, first allocate after reset, reserved, negative,
   // too large and empty indices, the unused mode, free then free again.
   localparam int DIR_ROWS = 19;
   dir_row_type directed_rows [DIR_ROWS] = '{
      '{nfsa_pkg::MODE_ALLOC,  32'h0000_0000, 8'h00, 1'b1,
        '{nfsa_pkg::STATUS_NULL,    6'd0, 32'h0}},
      '{nfsa_pkg::MODE_ALLOC,  32'hFFFF_FFFF, 8'hFF, 1'b1,
        '{nfsa_pkg::STATUS_OK,      6'd2, 32'h0}},
      '{nfsa_pkg::MODE_LOOKUP, 32'h0000_0000, 8'h02, 1'b1,
        '{nfsa_pkg::STATUS_OK,      6'd0, 32'hFFFF_FFFF}},
      '{nfsa_pkg::MODE_LOOKUP, 32'hFFFF_FFFF, 8'h00, 1'b1,
        '{nfsa_pkg::STATUS_INVALID, 6'd0, 32'h0}},
      '{nfsa_pkg::MODE_LOOKUP, 32'h0000_0000, 8'h01, 1'b1,
        '{nfsa_pkg::STATUS_INVALID, 6'd0, 32'h0}},
      '{nfsa_pkg::MODE_FREE,   32'h0000_0000, 8'h80, 1'b1,
        '{nfsa_pkg::STATUS_INVALID, 6'd0, 32'h0}},
      '{nfsa_pkg::MODE_LOOKUP, 32'h0000_0000, 8'h7F, 1'b1,
        '{nfsa_pkg::STATUS_INVALID, 6'd0, 32'h0}},
      '{nfsa_pkg::MODE_FREE,   32'h0000_0000, 8'hFF, 1'b1,
        '{nfsa_pkg::STATUS_INVALID, 6'd0, 32'h0}},
      '{nfsa_pkg::MODE_LOOKUP, 32'h0000_0000, 8'h40, 1'b1,
        '{nfsa_pkg::STATUS_INVALID, 6'd0, 32'h0}},
      '{nfsa_pkg::MODE_LOOKUP, 32'h0000_0000, 8'h3F, 1'b1,
        '{nfsa_pkg::STATUS_INVALID, 6'd0, 32'h0}},
      '{MODE_UNUSED,           32'hFFFF_FFFF, 8'h02, 1'b1,
        '{nfsa_pkg::STATUS_INVALID, 6'd0, 32'h0}},
      '{nfsa_pkg::MODE_ALLOC,  32'h0000_0001, 8'h00, 1'b1,
        '{nfsa_pkg::STATUS_OK,      6'd3, 32'h0}},
      '{nfsa_pkg::MODE_ALLOC,  32'h8000_0000, 8'h00, 1'b0, '0},
      '{nfsa_pkg::MODE_FREE,   32'h0000_0000, 8'h03, 1'b1,
        '{nfsa_pkg::STATUS_OK,      6'd0, 32'h1}},
      '{nfsa_pkg::MODE_FREE,   32'h0000_0000, 8'h03, 1'b1,
        '{nfsa_pkg::STATUS_INVALID, 6'd0, 32'h0}},
      '{nfsa_pkg::MODE_ALLOC,  32'h5A5A_5A5A, 8'h00, 1'b0, '0},
      '{nfsa_pkg::MODE_FREE,   32'hFFFF_FFFF, 8'h02, 1'b0, '0},
      '{nfsa_pkg::MODE_LOOKUP, 32'h0000_0000, 8'h04, 1'b0, '0},
      '{nfsa_pkg::MODE_FREE,   32'h0000_0000, 8'h05, 1'b0, '0}
   };

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata = '0;    // mode, handle, slot_index, zero pad
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;         // status, slot_out, handle_out

   // shadow copy of the handle table and the search hint
   logic [31:0] shadow_handles [SLOTS];
   int          shadow_hint;
   outcome_type pending_results [$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int fault_count   = 0;
   int cycle_count   = 0;
   int n_requests = 0, n_placed = 0, n_wrapped = 0, n_full = 0, n_null = 0;
   int n_rejected = 0, n_found = 0, n_freed = 0;

   next_fit_slot_allocator_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Work out the outcome of one request and advance the shadow table.
   function automatic outcome_type table_outcome(
      input logic [nfsa_pkg::MODE_W-1:0]  mode,
      input logic [31:0]                  handle,
      input logic [nfsa_pkg::INDEX_W-1:0] index);
      outcome_type r;
      int          found;
      int          slot;
      r = '{nfsa_pkg::STATUS_INVALID, '0, '0};
      n_requests++;
      if (mode == nfsa_pkg::MODE_ALLOC) begin
         if (handle == '0) begin
            r.status = nfsa_pkg::STATUS_NULL;
            n_null++;
         end else begin
            found = -1;
            // search from the hint to the end, then wrap round from the first usable slot
            for (int s = shadow_hint; s < SLOTS; s++)
               if (found < 0 && shadow_handles[s] == '0) found = s;
            for (int s = nfsa_pkg::FIRST_SLOT; s < shadow_hint; s++)
               if (found < 0 && shadow_handles[s] == '0) found = s;
            if (found < 0) begin
               r.status = nfsa_pkg::STATUS_FULL;
               r.handle = handle;
               n_full++;
            end else begin
               if (found < shadow_hint) n_wrapped++;
               shadow_handles[found] = handle;
               shadow_hint = found + 1;
               r.status = nfsa_pkg::STATUS_OK;
               r.slot = found[nfsa_pkg::SLOT_OUT_W-1:0];
               n_placed++;
            end
         end
      end else if (mode == nfsa_pkg::MODE_LOOKUP || mode == nfsa_pkg::MODE_FREE) begin
         slot = int'(index);
         // negative, reserved and out-of-range indices all fall through as rejects
         if (index[nfsa_pkg::INDEX_W-1] || slot < nfsa_pkg::FIRST_SLOT || slot >= SLOTS ||
             shadow_handles[slot] == '0) begin
            n_rejected++;
         end else begin
            r.status = nfsa_pkg::STATUS_OK;
            r.handle = shadow_handles[slot];
            if (mode == nfsa_pkg::MODE_FREE) begin
               shadow_handles[slot] = '0;
               n_freed++;
            end else begin
               n_found++;
            end
         end
      end else begin
         n_rejected++;
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      fault_count++;
      $display("[%0t] %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
   endtask

   // Offer one request; hold it until the transfer, then record what must come back.
   task automatic send_request(input logic [nfsa_pkg::MODE_W-1:0] mode,
                               input logic [31:0] handle,
                               input logic [nfsa_pkg::INDEX_W-1:0] index,
                               input logic known, input outcome_type want);
      outcome_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_W - nfsa_pkg::MODE_W - 32 - nfsa_pkg::INDEX_W){1'b0}},
                     index, handle, mode};
      do @(posedge clock); while (!req_tready);
      predicted = table_outcome(mode, handle, index);
      pending_results.push_back(known ? want : predicted);
   endtask

   // Hold the sender off until every outstanding result has drained.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   function automatic int pick_live_slot();
      int live [$];
      for (int s = nfsa_pkg::FIRST_SLOT; s < SLOTS; s++)
         if (shadow_handles[s] != '0) live.push_back(s);
      if (live.size() == 0) return $urandom_range(SLOTS - 1, nfsa_pkg::FIRST_SLOT);
      return live[$urandom_range(live.size() - 1)];
   endfunction

   // Random traffic in fill and drain bursts so the table reaches full and the hint wraps.
   task automatic random_phase(input int count);
      int                           alloc_pct;
      int                           burst_left;
      int                           pick;
      logic [nfsa_pkg::MODE_W-1:0]  mode;
      logic [31:0]                  handle;
      logic [nfsa_pkg::INDEX_W-1:0] index;
      alloc_pct  = 85;
      burst_left = $urandom_range(70, 20);
      for (int i = 0; i < count; i++) begin
         if (burst_left == 0) begin
            alloc_pct  = (alloc_pct > 50) ? 15 : 85;
            burst_left = $urandom_range(70, 20);
         end
         burst_left--;
         pick = $urandom_range(99);
         if (pick < 2)              mode = MODE_UNUSED;
         else if (pick < alloc_pct) mode = nfsa_pkg::MODE_ALLOC;
         else if (pick[0])          mode = nfsa_pkg::MODE_FREE;
         else                       mode = nfsa_pkg::MODE_LOOKUP;
         pick = $urandom_range(99);
         if (pick < 4)       handle = '0;
         else if (pick < 7)  handle = 32'h1 << $urandom_range(31);
         else if (pick < 9)  handle = '1;
         else                handle = $urandom;
         pick = $urandom_range(99);
         if (pick < 75)      index = 8'(pick_live_slot());
         else if (pick < 88) index = 8'($urandom_range(SLOTS - 1, nfsa_pkg::FIRST_SLOT));
         else                index = 8'($urandom_range(255));
         send_request(mode, handle, index, 1'b0, '0);
      end
   endtask

   // Check every result transfer against the oldest expectation.
   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result", 32'(rsp_tdata[RSP_W-1:0]), '0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_tdata[1:0] !== want.status)
               report_mismatch("status", 32'(rsp_tdata[1:0]), 32'(want.status));
            if (rsp_tdata[7:2] !== want.slot)
               report_mismatch("slot_out", 32'(rsp_tdata[7:2]), 32'(want.slot));
            if (rsp_tdata[39:8] !== want.handle)
               report_mismatch("handle_out", rsp_tdata[39:8], want.handle);
         end
      end
   end

   // Stall the result side at the rate of the current phase.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Abandon the run if it hangs.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == RUN_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  pending_results.size());
         $display("next_fit_slot_allocator_unit: mismatch");
         $finish;
      end
   end

   initial begin
      for (int s = 0; s < SLOTS; s++) shadow_handles[s] = '0;
      shadow_hint   = nfsa_pkg::FIRST_SLOT;
      send_idle_pct = 23;
      recv_idle_pct = 78;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < DIR_ROWS; r++)
         send_request(directed_rows[r].mode, directed_rows[r].handle, directed_rows[r].index,
                      directed_rows[r].known, directed_rows[r].want);
      random_phase(RAND_ITEMS);
      drain_results();

      send_idle_pct = 78;
      recv_idle_pct = 23;
      random_phase(RAND_ITEMS);
      drain_results();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_phase(RAND_ITEMS);
      drain_results();
      repeat (TAIL_WAIT) @(posedge clock);

      $display("%0d requests: %0d placed (%0d after wrap), %0d table full, %0d null handle",
               n_requests, n_placed, n_wrapped, n_full, n_null);
      $display("%0d look-ups found, %0d slots freed, %0d rejected, %0d field errors",
               n_found, n_freed, n_rejected, fault_count);
      if (fault_count == 0 && pending_results.size() == 0)
         $display("next_fit_slot_allocator_unit: match");
      else
         $display("next_fit_slot_allocator_unit: mismatch");
      $finish;
   end

endmodule
